/* rtl/core/dstwr_pkg.sv */
// Shared types and constants of the double-sided two-way ranging distance block.
// No dependencies; the top level, dstwr_prep and dstwr_div import it.

package dstwr_pkg;

   localparam int DELAY_W    = 16;
   localparam int DIST_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RX_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_DELAY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE    = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_DEN = 2'd2;

   // centimetres per time unit, Q0.24
   localparam logic [CSR_DATA_W-1:0] SCALE_RESET = 32'd7869280;

   typedef struct packed {
      logic bad_den;
      logic clamp;
      logic sat;
   } dstwr_flags_type;

endpackage

/* rtl/core/ds_twr_distance_calc.sv */
// Top level of the double-sided two-way ranging distance block.
// Depends on dstwr_pkg, dstwr_prep, dstwr_mul and dstwr_div.

// Computes (Ra*Rb - Da*Db) / (Ra+Rb+Da+Db) from one exchange's four intervals,
// with both antenna delays taken off the round times and added to the reply
// times, and scales it to centimetres by the Q0.24 register. Takes one exchange
// per cycle unless the output holds; each result passes through 2 correction
// stages, 2 stages per multiplier, a difference stage, a scaling stage, the
// 16-stage quotient chain and the output register. When a result is not
// taken, the whole pipeline holds. Status 2 flags a zero denominator, status 1
// a negative result clamped to 0 or a quotient saturated at 65535.
// Configuration writes are accepted in every cycle and are meant for idle time.

module ds_twr_distance_calc import dstwr_pkg::*; #(
   parameter int STAMP_BITS      = 32,
   parameter int SCALE_FRAC_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [STAMP_BITS-1:0] req_reply_time_one,
   input  logic [STAMP_BITS-1:0] req_reply_time_two,
   input  logic [STAMP_BITS-1:0] req_round_time_one,
   input  logic [STAMP_BITS-1:0] req_round_time_two,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DIST_W-1:0]     rsp_distance_cm,
   output logic [STATUS_W-1:0]   rsp_range_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int MAG_W  = STAMP_BITS + 1;
   localparam int COR_W  = STAMP_BITS + 2;
   localparam int P_W    = 2 * MAG_W;
   localparam int Q_W    = 2 * COR_W;
   localparam int DIFF_W = P_W;
   localparam int NUM_W  = DIFF_W + SCALE_FRAC_BITS;

   logic                       en;

   logic [DELAY_W-1:0]         rx_delay_ff, tx_delay_ff;
   logic [SCALE_FRAC_BITS-1:0] scale_ff;

   logic                       pv;
   logic [MAG_W-1:0]           mag_ra, mag_rb;
   logic                       pneg;
   logic [COR_W-1:0]           da, db, den;

   logic [P_W-1:0]             p_prod;
   logic [Q_W-1:0]             q_prod;
   logic                       mv1_ff, mv2_ff;
   logic                       mneg1_ff, mneg2_ff;
   logic [COR_W-1:0]           mden1_ff, mden2_ff;

   logic                       clamp_in;
   logic [DIFF_W-1:0]          diff_in, diff_ff;
   logic                       dv_ff, clamp_ff, bad_ff;
   logic [COR_W-1:0]           dden_ff;

   logic [NUM_W-1:0]           num;
   logic                       sv1_ff, sv2_ff;
   logic                       sclamp1_ff, sclamp2_ff, sbad1_ff, sbad2_ff;
   logic [COR_W-1:0]           sden1_ff, sden2_ff;

   logic [DIFF_W-1:0]          n2_in, n2_ff;
   dstwr_flags_type            nflags_in, nflags_ff;
   logic                       nv_ff;
   logic [COR_W-1:0]           nden_ff;

   logic                       qv;
   logic [DIST_W-1:0]          quo;
   dstwr_flags_type            qflags;

   logic                       rsp_valid_ff;
   logic [DIST_W-1:0]          dist_in, dist_ff;
   logic [STATUS_W-1:0]        status_in, status_ff;

   // the pipeline advances whenever the output register is free or drained
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_delay_ff <= '0;
         tx_delay_ff <= '0;
         scale_ff    <= SCALE_RESET[SCALE_FRAC_BITS-1:0];
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RX_DELAY: rx_delay_ff <= csr_wdata[DELAY_W-1:0];
            CSR_TX_DELAY: tx_delay_ff <= csr_wdata[DELAY_W-1:0];
            CSR_SCALE:    scale_ff    <= csr_wdata[SCALE_FRAC_BITS-1:0];
            default: begin
               // unused index: drop the write
            end
         endcase
      end
   end

   dstwr_prep #(.STAMP_BITS(STAMP_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .reply_one (req_reply_time_one),
      .reply_two (req_reply_time_two),
      .round_one (req_round_time_one),
      .round_two (req_round_time_two),
      .rx_delay  (rx_delay_ff),
      .tx_delay  (tx_delay_ff),
      .out_valid (pv),
      .mag_ra    (mag_ra),
      .mag_rb    (mag_rb),
      .prod_neg  (pneg),
      .da        (da),
      .db        (db),
      .den       (den)
   );

   dstwr_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_mul_round (
      .clock (clock),
      .en    (en),
      .a     (mag_ra),
      .b     (mag_rb),
      .prod  (p_prod)
   );

   dstwr_mul #(.A_W(COR_W), .B_W(COR_W)) u_mul_reply (
      .clock (clock),
      .en    (en),
      .a     (da),
      .b     (db),
      .prod  (q_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mv1_ff <= 1'b0;
         mv2_ff <= 1'b0;
      end else if (en) begin
         mv1_ff <= pv;
         mv2_ff <= mv1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mneg1_ff <= pneg;
         mneg2_ff <= mneg1_ff;
         mden1_ff <= den;
         mden2_ff <= mden1_ff;
      end
   end

   // a nonzero round product of opposite signs, or one below the reply
   // product, gives a negative distance
   assign clamp_in = (mneg2_ff && (p_prod != '0)) || (Q_W'(p_prod) < q_prod);
   assign diff_in  = DIFF_W'(Q_W'(p_prod) - q_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= 1'b0;
      end else if (en) begin
         dv_ff <= mv2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff  <= diff_in;
         clamp_ff <= clamp_in;
         bad_ff   <= (mden2_ff == '0);
         dden_ff  <= mden2_ff;
      end
   end

   dstwr_mul #(.A_W(DIFF_W), .B_W(SCALE_FRAC_BITS)) u_mul_scale (
      .clock (clock),
      .en    (en),
      .a     (diff_ff),
      .b     (scale_ff),
      .prod  (num)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sv1_ff <= 1'b0;
         sv2_ff <= 1'b0;
      end else if (en) begin
         sv1_ff <= dv_ff;
         sv2_ff <= sv1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sclamp1_ff <= clamp_ff;
         sclamp2_ff <= sclamp1_ff;
         sbad1_ff   <= bad_ff;
         sbad2_ff   <= sbad1_ff;
         sden1_ff   <= dden_ff;
         sden2_ff   <= sden1_ff;
      end
   end

   // the divisor carries only zeros below the scale's fraction bits, so the
   // fraction bits of the numerator never change the quotient
   assign n2_in             = num[NUM_W-1:SCALE_FRAC_BITS];
   assign nflags_in.bad_den = sbad2_ff;
   assign nflags_in.clamp   = sclamp2_ff;
   assign nflags_in.sat     = n2_in >= (DIFF_W'(sden2_ff) << DIST_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
      end else if (en) begin
         nv_ff <= sv2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n2_ff     <= n2_in;
         nflags_ff <= nflags_in;
         nden_ff   <= sden2_ff;
      end
   end

   dstwr_div #(.REM_W(DIFF_W), .DEN_W(COR_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nv_ff),
      .in_rem    (n2_ff),
      .in_den    (nden_ff),
      .in_flags  (nflags_ff),
      .out_valid (qv),
      .out_quo   (quo),
      .out_flags (qflags)
   );

   always_comb begin
      if (qflags.bad_den) begin
         dist_in   = '0;
         status_in = STATUS_BAD_DEN;
      end else if (qflags.clamp) begin
         dist_in   = '0;
         status_in = STATUS_LIMIT;
      end else if (qflags.sat) begin
         dist_in   = '1;
         status_in = STATUS_LIMIT;
      end else begin
         dist_in   = quo;
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= qv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff   <= dist_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance_cm  = dist_ff;
   assign rsp_range_status = status_ff;

endmodule

/* rtl/core/dstwr_prep.sv */
// Front end: antenna delay correction, denominator sum and operand magnitudes.
// Two register stages. Depends on dstwr_pkg.

module dstwr_prep import dstwr_pkg::*; #(
   parameter int STAMP_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [STAMP_BITS-1:0] reply_one,
   input  logic [STAMP_BITS-1:0] reply_two,
   input  logic [STAMP_BITS-1:0] round_one,
   input  logic [STAMP_BITS-1:0] round_two,
   input  logic [DELAY_W-1:0]    rx_delay,
   input  logic [DELAY_W-1:0]    tx_delay,
   output logic                  out_valid,
   output logic [STAMP_BITS:0]   mag_ra,
   output logic [STAMP_BITS:0]   mag_rb,
   output logic                  prod_neg,
   output logic [STAMP_BITS+1:0] da,
   output logic [STAMP_BITS+1:0] db,
   output logic [STAMP_BITS+1:0] den
);

   localparam int COR_W = STAMP_BITS + 2;
   localparam int MAG_W = STAMP_BITS + 1;

   logic [DELAY_W:0]          dly;
   logic [COR_W-1:0]          da_in, db_in, den_in;
   logic signed [COR_W-1:0]   ra_in, rb_in;
   logic [COR_W-1:0]          da_ff, db_ff, den_ff;
   logic signed [COR_W-1:0]   ra_ff, rb_ff;
   logic                      v1_ff;

   logic [MAG_W-1:0]          mag_ra_in, mag_rb_in;
   logic [MAG_W-1:0]          mag_ra_ff, mag_rb_ff;
   logic                      neg_in, neg_ff;
   logic [COR_W-1:0]          da2_ff, db2_ff, den2_ff;
   logic                      v2_ff;

   assign dly    = {1'b0, rx_delay} + {1'b0, tx_delay};
   assign da_in  = COR_W'(reply_two) + COR_W'(dly);
   assign db_in  = COR_W'(reply_one) + COR_W'(dly);
   assign ra_in  = $signed(COR_W'(round_one)) - $signed(COR_W'(dly));
   assign rb_in  = $signed(COR_W'(round_two)) - $signed(COR_W'(dly));
   // the delays cancel in the sum of all four corrected intervals
   assign den_in = COR_W'(reply_one) + COR_W'(reply_two)
                 + COR_W'(round_one) + COR_W'(round_two);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         da_ff  <= da_in;
         db_ff  <= db_in;
         ra_ff  <= ra_in;
         rb_ff  <= rb_in;
         den_ff <= den_in;
      end
   end

   assign mag_ra_in = ra_ff[COR_W-1] ? MAG_W'(-ra_ff) : MAG_W'(ra_ff);
   assign mag_rb_in = rb_ff[COR_W-1] ? MAG_W'(-rb_ff) : MAG_W'(rb_ff);
   assign neg_in    = ra_ff[COR_W-1] ^ rb_ff[COR_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ra_ff <= mag_ra_in;
         mag_rb_ff <= mag_rb_in;
         neg_ff    <= neg_in;
         da2_ff    <= da_ff;
         db2_ff    <= db_ff;
         den2_ff   <= den_ff;
      end
   end

   assign out_valid = v2_ff;
   assign mag_ra    = mag_ra_ff;
   assign mag_rb    = mag_rb_ff;
   assign prod_neg  = neg_ff;
   assign da        = da2_ff;
   assign db        = db2_ff;
   assign den       = den2_ff;

endmodule

/* rtl/core/dstwr_mul.sv */
// Two-stage unsigned multiplier: B is split in halves, partial products are
// registered, then summed. No dependencies.

module dstwr_mul #(
   parameter int A_W = 33,
   parameter int B_W = 33
) (
   input  logic               clock,
   input  logic               en,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] prod
);

   localparam int BL  = B_W / 2;
   localparam int BH  = B_W - BL;
   localparam int P_W = A_W + B_W;

   logic [A_W+BL-1:0] lo_in, lo_ff;
   logic [A_W+BH-1:0] hi_in, hi_ff;
   logic [P_W-1:0]    prod_in, prod_ff;

   assign lo_in   = (A_W+BL)'(a) * (A_W+BL)'(b[BL-1:0]);
   assign hi_in   = (A_W+BH)'(a) * (A_W+BH)'(b[B_W-1:BL]);
   assign prod_in = (P_W'(hi_ff) << BL) + P_W'(lo_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

/* rtl/core/dstwr_div.sv */
// Restoring divider, one quotient bit per register stage. The caller must keep
// the quotient in DIST_W bits; the divider does not check. Depends on dstwr_pkg.

module dstwr_div import dstwr_pkg::*; #(
   parameter int REM_W = 66,
   parameter int DEN_W = 34
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [REM_W-1:0] in_rem,
   input  logic [DEN_W-1:0] in_den,
   input  dstwr_flags_type in_flags,
   output logic            out_valid,
   output logic [DIST_W-1:0] out_quo,
   output dstwr_flags_type out_flags
);

   logic                  valid_ff [DIST_W];
   logic [REM_W-1:0]      rem_ff   [DIST_W];
   logic [DEN_W-1:0]      den_ff   [DIST_W];
   logic [DIST_W-1:0]     quo_ff   [DIST_W];
   dstwr_flags_type       flags_ff [DIST_W];

   for (genvar k = 0; k < DIST_W; k++) begin : g_step
      logic              valid_src;
      logic [REM_W-1:0]  rem_src, trial, rem_in;
      logic [DEN_W-1:0]  den_src;
      logic [DIST_W-1:0] quo_src, quo_in;
      dstwr_flags_type   flags_src;
      logic              hit;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_rem;
         assign den_src   = in_den;
         assign quo_src   = '0;
         assign flags_src = in_flags;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign quo_src   = quo_ff[k-1];
         assign flags_src = flags_ff[k-1];
      end

      assign trial  = REM_W'(den_src) << (DIST_W - 1 - k);
      assign hit    = rem_src >= trial;
      assign rem_in = hit ? rem_src - trial : rem_src;
      assign quo_in = quo_src | (DIST_W'(hit) << (DIST_W - 1 - k));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]   <= rem_in;
            den_ff[k]   <= den_src;
            quo_ff[k]   <= quo_in;
            flags_ff[k] <= flags_src;
         end
      end
   end

   assign out_valid = valid_ff[DIST_W-1];
   assign out_quo   = quo_ff[DIST_W-1];
   assign out_flags = flags_ff[DIST_W-1];

endmodule
